FILE: rtl/lsu_pkg.sv
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types and constants of the MIPS load/store unit: item structs,
// opcodes, exception codes, memory geometry and the sequencer states.
// ----------------------------------------------------------------------------
package lsu_pkg;

    localparam int MEM_DOUBLEWORDS = 256;
    localparam int MEM_IDX_W       = $clog2(MEM_DOUBLEWORDS);

    localparam logic [4:0] OP_LB  = 5'd0;
    localparam logic [4:0] OP_LBU = 5'd1;
    localparam logic [4:0] OP_LH  = 5'd2;
    localparam logic [4:0] OP_LHU = 5'd3;
    localparam logic [4:0] OP_LW  = 5'd4;
    localparam logic [4:0] OP_LWU = 5'd5;
    localparam logic [4:0] OP_LD  = 5'd6;
    localparam logic [4:0] OP_LL  = 5'd7;
    localparam logic [4:0] OP_LWL = 5'd8;
    localparam logic [4:0] OP_LWR = 5'd9;
    localparam logic [4:0] OP_LDL = 5'd10;
    localparam logic [4:0] OP_LDR = 5'd11;
    localparam logic [4:0] OP_SB  = 5'd12;
    localparam logic [4:0] OP_SH  = 5'd13;
    localparam logic [4:0] OP_SW  = 5'd14;
    localparam logic [4:0] OP_SD  = 5'd15;
    localparam logic [4:0] OP_SC  = 5'd16;
    localparam logic [4:0] OP_SWL = 5'd17;
    localparam logic [4:0] OP_SWR = 5'd18;
    localparam logic [4:0] OP_SDL = 5'd19;
    localparam logic [4:0] OP_SDR = 5'd20;

    localparam logic [1:0] EXC_NONE = 2'd0;
    localparam logic [1:0] EXC_ADEL = 2'd1;
    localparam logic [1:0] EXC_ADES = 2'd2;
    localparam logic [1:0] EXC_RI   = 2'd3;

    localparam logic REG_MODE64 = 1'b0;
    localparam logic REG_KERNEL = 1'b1;

    localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] LOW32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0]         op;
        logic [63:0]        base_value;
        logic signed [15:0] offset;
        logic [63:0]        reg_old;
    } t_lsu_in;

    typedef struct packed {
        logic [63:0] reg_value;
        logic        write_reg;
        logic [1:0]  exception;
        logic [63:0] fault_address;
    } t_lsu_out;

    typedef struct packed {
        logic [63:0] reg_value;
        logic        write_reg;
        logic [1:0]  exception;
        logic        mem_we;
        logic [63:0] mem_wdata;
        logic        link_set;
    } t_lsu_exec_res;

    typedef struct packed {
        logic mode64;
        logic kernel_mode;
    } t_lsu_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_EXEC
    } t_lsu_state;

endpackage

FILE: rtl/mips_load_store_unit.sv
// ----------------------------------------------------------------------------
// mips_load_store_unit
// Big-endian MIPS III load/store unit with a private doubleword data memory.
// ----------------------------------------------------------------------------
// An item enters on the input channel (i_in_valid, o_in_stall) carrying the
// opcode, base register, signed offset and old target register. The result
// item leaves on the output channel (o_out_valid, i_out_stall) with the new
// target value, its write enable, the exception code and the effective
// address.
// Each item passes through the states S_IDLE, where it is accepted, S_ADDR,
// which forms the effective address and starts the memory read, and S_EXEC,
// which merges, checks and writes the modified doubleword back and registers
// the result in the output register. A new item is taken only back in S_IDLE,
// so the unit does not take a new item before the last one has left S_EXEC.
// The result sits in an output register, so the next item is accepted while
// it waits; if the receiver stalls that long, the next item holds in its
// final cycle until the output register frees up.
// Reset empties the pipeline, clears the link bit, sets the mode registers
// to 32-bit kernel mode and makes the whole memory read as zero at once.
// Configuration must be written over the APB-style port while idle; unchecked.
// ----------------------------------------------------------------------------
module mips_load_store_unit
    import lsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_lsu_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_lsu_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_lsu_state    r_state;
    t_lsu_state    n_state;
    t_lsu_in       r_item;
    logic [63:0]   r_ea;
    logic [63:0]   n_ea;
    logic          r_link;
    logic          r_out_valid;
    logic          n_out_valid;
    t_lsu_out      r_out;
    t_lsu_cfg      cfg;
    t_lsu_exec_res res;
    logic [63:0]   rdata;
    logic          take_in;
    logic          load_ea;
    logic          exec_fire;
    logic          out_free;

    lsu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign n_ea = r_item.base_value + {{48{r_item.offset[15]}}, r_item.offset};

    lsu_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (n_ea[3 +: MEM_IDX_W]),
        .i_we    (exec_fire && res.mem_we),
        .i_waddr (r_ea[3 +: MEM_IDX_W]),
        .i_wdata (res.mem_wdata),
        .o_rdata (rdata)
    );

    lsu_exec u_exec (
        .i_op    (r_item.op),
        .i_ea    (r_ea),
        .i_rt    (r_item.reg_old),
        .i_rdata (rdata),
        .i_link  (r_link),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        load_ea    = 1'b0;
        exec_fire  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_ADDR: begin
                load_ea = 1'b1;
            end
            S_EXEC: begin
                exec_fire = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign take_in     = i_in_valid && !o_in_stall;
    assign n_out_valid = exec_fire || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (exec_fire && res.link_set) begin
                r_link <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_item <= i_in_data;
        end
        if (load_ea) begin
            r_ea <= n_ea;
        end
        if (exec_fire) begin
            r_out.reg_value     <= res.reg_value;
            r_out.write_reg     <= res.write_reg;
            r_out.exception     <= res.exception;
            r_out.fault_address <= r_ea;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/lsu_dmem.sv
// ----------------------------------------------------------------------------
// lsu_dmem
// Doubleword data memory with a registered read port, one write port and a
// valid bit per entry, so that entries never written read as zero.
// ----------------------------------------------------------------------------
module lsu_dmem
    import lsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [MEM_IDX_W-1:0] i_raddr,
    input  logic                 i_we,
    input  logic [MEM_IDX_W-1:0] i_waddr,
    input  logic [63:0]          i_wdata,
    output logic [63:0]          o_rdata
);

    logic [63:0]                r_mem [MEM_DOUBLEWORDS];
    logic [MEM_DOUBLEWORDS-1:0] r_valid;
    logic [63:0]                r_rdata;
    logic                       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 64'd0;

endmodule

FILE: rtl/lsu_cfg.sv
// ----------------------------------------------------------------------------
// lsu_cfg
// Configuration registers behind the APB-style port: addressing mode and
// operating mode.
// ----------------------------------------------------------------------------
module lsu_cfg
    import lsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_lsu_cfg    o_cfg
);

    logic r_mode64;
    logic r_kernel;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode64 <= 1'b0;
            r_kernel <= 1'b1;
        end else if (wr_en) begin
            if (paddr[2] == REG_MODE64) begin
                r_mode64 <= pwdata[0];
            end else begin
                r_kernel <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_MODE64) ? {31'd0, r_mode64} : {31'd0, r_kernel};

    assign o_cfg.mode64      = r_mode64;
    assign o_cfg.kernel_mode = r_kernel;

endmodule

FILE: rtl/lsu_exec.sv
// ----------------------------------------------------------------------------
// lsu_exec
// Execute datapath: address checks, lane extraction, load extension and
// merging, and the modified doubleword for stores.
// ----------------------------------------------------------------------------
module lsu_exec
    import lsu_pkg::*;
(
    input  logic [4:0]    i_op,
    input  logic [63:0]   i_ea,
    input  logic [63:0]   i_rt,
    input  logic [63:0]   i_rdata,
    input  logic          i_link,
    input  t_lsu_cfg      i_cfg,
    output t_lsu_exec_res o_res
);

    logic [2:0]  k8;
    logic [1:0]  k4;
    logic [5:0]  byte_sh;
    logic [5:0]  half_sh;
    logic [5:0]  word_sh;
    logic [4:0]  sh4;
    logic [4:0]  shr4;
    logic [5:0]  sh8;
    logic [5:0]  shr8;
    logic [7:0]  bval;
    logic [15:0] hval;
    logic [31:0] wval;
    logic [31:0] lwl_m;
    logic [31:0] lwr_m;
    logic [31:0] swl_m;
    logic [31:0] swr_m;
    logic [63:0] sdl_m;
    logic [63:0] sdr_m;
    logic [31:0] merge32;
    logic        not_sext;
    logic        bad_mode;
    logic [63:0] st_m;
    logic [5:0]  st_sh;
    logic [63:0] st_v;
    logic        st_en;
    logic [63:0] val;
    logic        wr;
    logic [1:0]  exc;
    logic        link_set;

    always_comb begin
        k8       = i_ea[2:0];
        k4       = i_ea[1:0];
        byte_sh  = {3'd7 - k8, 3'b000};
        half_sh  = {3'd6 - {k8[2:1], 1'b0}, 3'b000};
        word_sh  = k8[2] ? 6'd0 : 6'd32;
        sh4      = {k4, 3'b000};
        shr4     = {2'd3 - k4, 3'b000};
        sh8      = {k8, 3'b000};
        shr8     = {3'd7 - k8, 3'b000};
        bval     = 8'(i_rdata >> byte_sh);
        hval     = 16'(i_rdata >> half_sh);
        wval     = k8[2] ? i_rdata[31:0] : i_rdata[63:32];
        lwl_m    = LOW32 << sh4;
        lwr_m    = LOW32 >> shr4;
        swl_m    = LOW32 << (6'd32 - {1'b0, sh4});
        swr_m    = LOW32 >> ({1'b0, sh4} + 6'd8);
        sdl_m    = ALL64 << (7'd64 - {1'b0, sh8});
        sdr_m    = ALL64 >> ({1'b0, sh8} + 7'd8);
        not_sext = !i_ea[63] && (i_ea[62:31] != '0);
        bad_mode = !i_cfg.mode64 && !i_cfg.kernel_mode;
        merge32  = '0;
        st_m     = '0;
        st_sh    = '0;
        st_v     = '0;
        st_en    = 1'b0;
        val      = i_rt;
        wr       = 1'b0;
        exc      = EXC_NONE;
        link_set = 1'b0;

        case (i_op)
            OP_LB: begin
                val = {{56{bval[7]}}, bval};
                wr  = 1'b1;
            end
            OP_LBU: begin
                val = {56'd0, bval};
                wr  = 1'b1;
            end
            OP_LH: begin
                if (i_ea[0]) begin
                    exc = EXC_ADEL;
                end else begin
                    val = {{48{hval[15]}}, hval};
                    wr  = 1'b1;
                end
            end
            OP_LHU: begin
                val = {48'd0, hval};
                wr  = 1'b1;
            end
            OP_LW: begin
                if ((k4 != 2'd0) || not_sext) begin
                    exc = EXC_ADEL;
                end else begin
                    val = {{32{wval[31]}}, wval};
                    wr  = 1'b1;
                end
            end
            OP_LWU: begin
                val = {32'd0, wval};
                wr  = 1'b1;
            end
            OP_LD: begin
                if (k8 != 3'd0) begin
                    exc = EXC_ADEL;
                end else if (bad_mode) begin
                    exc = EXC_RI;
                end else begin
                    val = i_rdata;
                    wr  = 1'b1;
                end
            end
            OP_LL: begin
                if (k4 != 2'd0) begin
                    exc = EXC_ADEL;
                end else begin
                    val      = {{32{wval[31]}}, wval};
                    wr       = 1'b1;
                    link_set = 1'b1;
                end
            end
            OP_LWL: begin
                merge32 = (i_rt[31:0] & ~lwl_m) | (wval << sh4);
                val     = {{32{merge32[31]}}, merge32};
                wr      = 1'b1;
            end
            OP_LWR: begin
                merge32 = (i_rt[31:0] & ~lwr_m) | (wval >> shr4);
                val     = {{32{merge32[31]}}, merge32};
                wr      = 1'b1;
            end
            OP_LDL: begin
                val = (i_rt & ~(ALL64 << sh8)) | (i_rdata << sh8);
                wr  = 1'b1;
            end
            OP_LDR: begin
                val = (i_rt & ~(ALL64 >> shr8)) | (i_rdata >> shr8);
                wr  = 1'b1;
            end
            OP_SB: begin
                st_en = 1'b1;
                st_m  = 64'h0000_0000_0000_00FF;
                st_sh = byte_sh;
                st_v  = i_rt;
            end
            OP_SH: begin
                if (i_ea[0]) begin
                    exc = EXC_ADES;
                end else begin
                    st_en = 1'b1;
                    st_m  = 64'h0000_0000_0000_FFFF;
                    st_sh = half_sh;
                    st_v  = i_rt;
                end
            end
            OP_SW: begin
                if ((k4 != 2'd0) || not_sext) begin
                    exc = EXC_ADES;
                end else begin
                    st_en = 1'b1;
                    st_m  = {32'd0, LOW32};
                    st_sh = word_sh;
                    st_v  = i_rt;
                end
            end
            OP_SD: begin
                if (k8 != 3'd0) begin
                    exc = EXC_ADES;
                end else if (bad_mode) begin
                    exc = EXC_RI;
                end else begin
                    st_en = 1'b1;
                    st_m  = ALL64;
                    st_v  = i_rt;
                end
            end
            OP_SC: begin
                if (k4 != 2'd0) begin
                    exc = EXC_ADES;
                end else if (i_link) begin
                    st_en = 1'b1;
                    st_m  = {32'd0, LOW32};
                    st_sh = word_sh;
                    st_v  = i_rt;
                    val   = 64'd1;
                    wr    = 1'b1;
                end else begin
                    val = 64'd0;
                    wr  = 1'b1;
                end
            end
            OP_SWL: begin
                st_en = 1'b1;
                st_m  = {32'd0, LOW32};
                st_sh = word_sh;
                st_v  = {32'd0, (wval & swl_m) | (i_rt[31:0] >> sh4)};
            end
            OP_SWR: begin
                st_en = 1'b1;
                st_m  = {32'd0, LOW32};
                st_sh = word_sh;
                st_v  = {32'd0, (wval & swr_m) | (i_rt[31:0] << shr4)};
            end
            OP_SDL: begin
                st_en = 1'b1;
                st_m  = ALL64;
                st_v  = (i_rdata & sdl_m) | (i_rt >> sh8);
            end
            OP_SDR: begin
                st_en = 1'b1;
                st_m  = ALL64;
                st_v  = (i_rdata & sdr_m) | (i_rt << shr8);
            end
            default: begin
                exc = EXC_RI;
            end
        endcase

        if (exc != EXC_NONE) begin
            val      = i_rt;
            wr       = 1'b0;
            st_en    = 1'b0;
            link_set = 1'b0;
        end

        o_res.reg_value = val;
        o_res.write_reg = wr;
        o_res.exception = exc;
        o_res.mem_we    = st_en;
        o_res.mem_wdata = (i_rdata & ~(st_m << st_sh)) | ((st_v & st_m) << st_sh);
        o_res.link_set  = link_set;
    end

endmodule

FILE: dv/mips_load_store_unit_tb.sv
// ----------------------------------------------------------------------------
// mips_load_store_unit_tb
// Self-checking testbench for the big-endian MIPS III load/store unit.
// ----------------------------------------------------------------------------
// Directed rows cover field extremes, all opcodes but SB and LDR, alignment,
// sign-extension and user-mode faults, undefined opcodes and the LL/SC link.
// Random items then run under all four mode settings, with and without
// sender gaps and receiver stalls. Each accepted item is run through a local
// model of the unit and its memory, and every result item is compared field
// by field with the oldest expected one.
// ----------------------------------------------------------------------------
module mips_load_store_unit_tb
    import lsu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0]  OP_UNDEF_LO   = 5'd21;
    localparam logic [4:0]  OP_UNDEF_HI   = 5'd31;
    localparam logic [63:0] WORD_MASK     = {32'd0, LOW32};
    localparam int          DIR_ROWS      = 27;
    localparam int          USER_ROWS     = 3;
    localparam int          PHASE_ITEMS   = 125;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          QUIET_LIMIT   = 5000;
    localparam int          PRINT_LIMIT   = 60;

    typedef struct packed {
        t_lsu_in  item;
        logic     has_want;
        t_lsu_out want;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_lsu_in     i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_lsu_out    o_out_data;
    logic [31:0] prdata;
    logic        pready;

    logic        row_has_want = 1'b0;
    t_lsu_out    row_want     = '0;

    logic [63:0] dw_mem [MEM_DOUBLEWORDS];
    logic        link_flag;
    logic        cfg_mode64;
    logic        cfg_kernel;

    t_lsu_out    expected_q [$];
    int          err_count    = 0;
    int          quiet_cycles = 0;
    int          gap_pct      = 0;
    int          stall_pct    = 0;
    t_row        dir_rows [DIR_ROWS];

    mips_load_store_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [63:0] byte_mask(int unsigned n);
        return (n >= 8) ? ALL64 : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic logic [63:0] sext_bytes(logic [63:0] v, int unsigned n);
        logic [63:0] m;
        m = byte_mask(n);
        v = v & m;
        return v[8 * n - 1] ? (v | ~m) : v;
    endfunction

    function automatic logic [63:0] lane_read(logic [63:0] ea, int unsigned n);
        int unsigned lane;
        int unsigned sh;
        lane = ea[2:0] & ~(n - 1);
        sh   = 8 * (8 - n - lane);
        return (dw_mem[ea[MEM_IDX_W+2:3]] >> sh) & byte_mask(n);
    endfunction

    function automatic void lane_write(logic [63:0] ea, int unsigned n, logic [63:0] v);
        int unsigned lane;
        int unsigned sh;
        logic [63:0] m;
        lane = ea[2:0] & ~(n - 1);
        sh   = 8 * (8 - n - lane);
        m    = byte_mask(n);
        dw_mem[ea[MEM_IDX_W+2:3]] = (dw_mem[ea[MEM_IDX_W+2:3]] & ~(m << sh))
                                  | ((v & m) << sh);
    endfunction

    function automatic t_lsu_out lsu_execute(t_lsu_in it);
        t_lsu_out    r;
        logic [63:0] ea;
        logic [63:0] rt;
        logic [63:0] val;
        logic [63:0] w;
        logic [63:0] d;
        logic [63:0] m;
        logic [1:0]  exc;
        logic        wr;
        logic        bad_mode;
        logic        not_sext;
        int unsigned k8;
        int unsigned k4;
        int unsigned sh;
        rt       = it.reg_old;
        ea       = it.base_value + {{48{it.offset[15]}}, it.offset};
        k8       = ea[2:0];
        k4       = ea[1:0];
        val      = rt;
        wr       = 1'b0;
        exc      = EXC_NONE;
        bad_mode = !cfg_mode64 && !cfg_kernel;
        not_sext = (ea[62:31] != '0) && !ea[63];
        case (it.op)
            OP_LB: begin
                val = sext_bytes(lane_read(ea, 1), 1);
                wr  = 1'b1;
            end
            OP_LBU: begin
                val = lane_read(ea, 1);
                wr  = 1'b1;
            end
            OP_LH: begin
                if (ea[0]) begin
                    exc = EXC_ADEL;
                end else begin
                    val = sext_bytes(lane_read(ea, 2), 2);
                    wr  = 1'b1;
                end
            end
            OP_LHU: begin
                val = lane_read(ea, 2);
                wr  = 1'b1;
            end
            OP_LW: begin
                if (ea[1:0] != 2'd0 || not_sext) begin
                    exc = EXC_ADEL;
                end else begin
                    val = sext_bytes(lane_read(ea, 4), 4);
                    wr  = 1'b1;
                end
            end
            OP_LWU: begin
                val = lane_read(ea, 4);
                wr  = 1'b1;
            end
            OP_LD: begin
                if (ea[2:0] != 3'd0) begin
                    exc = EXC_ADEL;
                end else if (bad_mode) begin
                    exc = EXC_RI;
                end else begin
                    val = lane_read(ea, 8);
                    wr  = 1'b1;
                end
            end
            OP_LL: begin
                if (ea[1:0] != 2'd0) begin
                    exc = EXC_ADEL;
                end else begin
                    val       = sext_bytes(lane_read(ea, 4), 4);
                    wr        = 1'b1;
                    link_flag = 1'b1;
                end
            end
            OP_LWL: begin
                w   = lane_read(ea, 4);
                sh  = 8 * k4;
                m   = (WORD_MASK << sh) & WORD_MASK;
                val = sext_bytes((rt & WORD_MASK & ~m) | ((w << sh) & WORD_MASK), 4);
                wr  = 1'b1;
            end
            OP_LWR: begin
                w   = lane_read(ea, 4);
                sh  = 8 * (3 - k4);
                m   = WORD_MASK >> sh;
                val = sext_bytes((rt & WORD_MASK & ~m) | (w >> sh), 4);
                wr  = 1'b1;
            end
            OP_LDL: begin
                d   = lane_read(ea, 8);
                sh  = 8 * k8;
                m   = ALL64 << sh;
                val = (rt & ~m) | (d << sh);
                wr  = 1'b1;
            end
            OP_LDR: begin
                d   = lane_read(ea, 8);
                sh  = 8 * (7 - k8);
                m   = ALL64 >> sh;
                val = (rt & ~m) | (d >> sh);
                wr  = 1'b1;
            end
            OP_SB: begin
                lane_write(ea, 1, rt);
            end
            OP_SH: begin
                if (ea[0]) begin
                    exc = EXC_ADES;
                end else begin
                    lane_write(ea, 2, rt);
                end
            end
            OP_SW: begin
                if (ea[1:0] != 2'd0 || not_sext) begin
                    exc = EXC_ADES;
                end else begin
                    lane_write(ea, 4, rt);
                end
            end
            OP_SD: begin
                if (ea[2:0] != 3'd0) begin
                    exc = EXC_ADES;
                end else if (bad_mode) begin
                    exc = EXC_RI;
                end else begin
                    lane_write(ea, 8, rt);
                end
            end
            OP_SC: begin
                if (ea[1:0] != 2'd0) begin
                    exc = EXC_ADES;
                end else if (link_flag) begin
                    lane_write(ea, 4, rt);
                    val = 64'd1;
                    wr  = 1'b1;
                end else begin
                    val = 64'd0;
                    wr  = 1'b1;
                end
            end
            OP_SWL: begin
                w = lane_read(ea, 4);
                m = (WORD_MASK << (32 - 8 * k4)) & WORD_MASK;
                lane_write(ea, 4, (w & m) | ((rt & WORD_MASK) >> (8 * k4)));
            end
            OP_SWR: begin
                w = lane_read(ea, 4);
                m = WORD_MASK >> (8 * k4 + 8);
                lane_write(ea, 4, (w & m) | ((rt << (24 - 8 * k4)) & WORD_MASK));
            end
            OP_SDL: begin
                d = lane_read(ea, 8);
                m = (k8 == 0) ? 64'd0 : (ALL64 << (64 - 8 * k8));
                lane_write(ea, 8, (d & m) | (rt >> (8 * k8)));
            end
            OP_SDR: begin
                d = lane_read(ea, 8);
                m = (k8 == 7) ? 64'd0 : (ALL64 >> (8 * k8 + 8));
                lane_write(ea, 8, (d & m) | (rt << (56 - 8 * k8)));
            end
            default: begin
                exc = EXC_RI;
            end
        endcase
        if (exc != EXC_NONE || !wr) begin
            val = rt;
            wr  = 1'b0;
        end
        r.reg_value     = val;
        r.write_reg     = wr;
        r.exception     = exc;
        r.fault_address = ea;
        return r;
    endfunction

    function automatic t_row fx(logic [4:0] op, logic [63:0] base, logic [15:0] off,
                                logic [63:0] rt, logic [63:0] val, logic wr,
                                logic [1:0] exc, logic [63:0] fa);
        t_row r;
        r.item     = '{op: op, base_value: base, offset: off, reg_old: rt};
        r.has_want = 1'b1;
        r.want     = '{reg_value: val, write_reg: wr, exception: exc, fault_address: fa};
        return r;
    endfunction

    function automatic t_row pr(logic [4:0] op, logic [63:0] base, logic [15:0] off,
                                logic [63:0] rt);
        t_row r;
        r          = '0;
        r.item     = '{op: op, base_value: base, offset: off, reg_old: rt};
        return r;
    endfunction

    function automatic t_lsu_in rand_item(logic [4:0] op);
        t_lsu_in     it;
        logic [63:0] ea;
        logic [15:0] off;
        int unsigned align;
        ea = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: ea[63:11] = '0;
            6, 7:             ea[63:31] = '1;
            8:                ea[63:31] = 33'd1;
            default:          ;
        endcase
        if ($urandom_range(3) != 0) begin
            ea[10:7] = '0;
        end
        case (op)
            OP_LH, OP_LHU, OP_SH:                 align = 2;
            OP_LW, OP_LWU, OP_LL, OP_SW, OP_SC:   align = 4;
            OP_LD, OP_SD:                         align = 8;
            default:                              align = 1;
        endcase
        if ($urandom_range(99) < 85) begin
            ea[2:0] = ea[2:0] & ~3'(align - 1);
        end
        off           = $urandom;
        it.op         = op;
        it.offset     = off;
        it.base_value = ea - {{48{off[15]}}, off};
        case ($urandom_range(7))
            0:       it.reg_old = '0;
            1:       it.reg_old = '1;
            default: it.reg_old = {$urandom, $urandom};
        endcase
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (err_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    task automatic send_item(t_lsu_in it, logic has_want, t_lsu_out want);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_data    <= it;
        row_has_want <= has_want;
        row_want     <= want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        do @(posedge i_clk); while (expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic idx, logic val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MODE64) begin
            cfg_mode64 = val;
        end else begin
            cfg_kernel = val;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'd0, val}) begin
            report_mismatch("register read-back", {32'd0, prdata}, {63'd0, val});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_lsu_out want;
        logic     moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                want = lsu_execute(i_in_data);
                if (row_has_want) begin
                    want = row_want;
                end
                expected_q.push_back(want);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data.reg_value, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_data.reg_value !== want.reg_value) begin
                        report_mismatch("reg_value", o_out_data.reg_value, want.reg_value);
                    end
                    if (o_out_data.write_reg !== want.write_reg) begin
                        report_mismatch("write_reg", {63'd0, o_out_data.write_reg},
                                        {63'd0, want.write_reg});
                    end
                    if (o_out_data.exception !== want.exception) begin
                        report_mismatch("exception", {62'd0, o_out_data.exception},
                                        {62'd0, want.exception});
                    end
                    if (o_out_data.fault_address !== want.fault_address) begin
                        report_mismatch("fault_address", o_out_data.fault_address,
                                        want.fault_address);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : main
        t_lsu_in     it;
        logic [4:0]  op;
        int          ph;
        int          n;
        int          gap_plan [4];
        int          stall_plan [4];

        gap_plan   = '{0, 61, 0, 25};
        stall_plan = '{0, 0, 61, 25};
        foreach (dw_mem[i]) begin
            dw_mem[i] = '0;
        end
        link_flag  = 1'b0;
        cfg_mode64 = 1'b0;
        cfg_kernel = 1'b1;

        dir_rows = '{
            fx(OP_SC, 64'h10, 16'h0, 64'h5555_5555_5555_5555, 64'h0, 1'b1, EXC_NONE, 64'h10),
            fx(OP_LH, 64'h1, 16'h0, 64'hAAAA, 64'hAAAA, 1'b0, EXC_ADEL, 64'h1),
            fx(OP_LW, 64'h8000_0000, 16'h0, 64'h0, 64'h0, 1'b0, EXC_ADEL, 64'h8000_0000),
            fx(OP_LW, 64'hFFFF_FFFF_8000_0000, 16'h0, ALL64, 64'h0, 1'b1, EXC_NONE,
               64'hFFFF_FFFF_8000_0000),
            fx(OP_SW, 64'h2, 16'h0, ALL64, ALL64, 1'b0, EXC_ADES, 64'h2),
            fx(OP_SD, 64'h8, 16'h0, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF,
               1'b0, EXC_NONE, 64'h8),
            fx(OP_LD, 64'h10, 16'hFFF8, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b1, EXC_NONE,
               64'h8),
            fx(OP_LB, 64'h10, 16'hFFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFEF, 1'b1, EXC_NONE,
               64'hF),
            fx(OP_LBU, 64'h8008, 16'h8000, ALL64, 64'h1, 1'b1, EXC_NONE, 64'h8),
            fx(OP_LH, 64'h0, 16'h7FFF, 64'h0, 64'h0, 1'b0, EXC_ADEL, 64'h7FFF),
            fx(OP_UNDEF_LO, 64'h40, 16'h0, 64'h1234, 64'h1234, 1'b0, EXC_RI, 64'h40),
            fx(OP_UNDEF_HI, ALL64, 16'h7FFF, 64'h0, 64'h0, 1'b0, EXC_RI, 64'h7FFE),
            fx(OP_LHU, ALL64, 16'h1, ALL64, 64'h0, 1'b1, EXC_NONE, 64'h0),
            fx(OP_LL, 64'h8, 16'h0, 64'h0, 64'h0123_4567, 1'b1, EXC_NONE, 64'h8),
            fx(OP_SC, 64'h10, 16'h0, 64'hDEAD_BEEF_CAFE_F00D, 64'h1, 1'b1, EXC_NONE,
               64'h10),
            pr(OP_LWU, 64'h10, 16'h0, 64'h0),
            pr(OP_SH, 64'h16, 16'h0, 64'hBEEF),
            pr(OP_SWL, 64'h19, 16'h0, 64'h1122_3344_5566_7788),
            pr(OP_SWR, 64'h1E, 16'h0, 64'h99AA_BBCC_DDEE_FF00),
            pr(OP_SDL, 64'h23, 16'h0, 64'h0F1E_2D3C_4B5A_6978),
            pr(OP_SDR, 64'h25, 16'h0, 64'h8796_A5B4_C3D2_E1F0),
            pr(OP_LWL, 64'h11, 16'h0, ALL64),
            pr(OP_LWR, 64'h1A, 16'h0, 64'h0),
            pr(OP_LDL, 64'h0B, 16'h0, 64'h5A5A_5A5A_5A5A_5A5A),
            fx(OP_LD, 64'hC, 16'h0, 64'h0, 64'h0, 1'b0, EXC_ADEL, 64'hC),
            fx(OP_LD, 64'h8, 16'h0, 64'h77, 64'h77, 1'b0, EXC_RI, 64'h8),
            fx(OP_SD, 64'h0, 16'h0, ALL64, ALL64, 1'b0, EXC_RI, 64'h0)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_ROWS - USER_ROWS) begin
                i_in_valid <= 1'b0;
                drain();
                apb_write(REG_KERNEL, 1'b0);
            end
            send_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);
        end
        i_in_valid <= 1'b0;

        for (ph = 0; ph < 4; ph++) begin
            drain();
            apb_write(REG_MODE64, ph[0]);
            apb_write(REG_KERNEL, ph[1]);
            gap_pct   = gap_plan[ph];
            stall_pct = stall_plan[ph];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    i_in_valid <= 1'b0;
                    drain();
                end
                if ($urandom_range(9) == 0) begin
                    it = rand_item(OP_LL);
                    send_item(it, 1'b0, '0);
                    it.op      = OP_SC;
                    it.reg_old = {$urandom, $urandom};
                    send_item(it, 1'b0, '0);
                end else begin
                    if ($urandom_range(19) == 0) begin
                        op = 5'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
                    end else begin
                        op = 5'($urandom_range(OP_LB, OP_SDR));
                    end
                    send_item(rand_item(op), 1'b0, '0);
                end
            end
            i_in_valid <= 1'b0;
        end

        drain();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lsu_pkg.sv
rtl/lsu_dmem.sv
rtl/lsu_cfg.sv
rtl/lsu_exec.sv
rtl/mips_load_store_unit.sv
dv/mips_load_store_unit_tb.sv
